// ===== hdl/mlbf_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the MAC learning bridge forwarding unit.
// No dependencies; every other file in hdl/ refers to this package by scope.
package mlbf_pkg;

  // Default sizes, handed to the top-level parameters
  localparam int TABLE_ENTRIES_DEF = 64;
  localparam int MAX_PORTS_DEF     = 8;

  // Field widths
  localparam int OP_W    = 2;
  localparam int MAC_W   = 48;
  localparam int PORT_W  = 3;
  localparam int TIME_W  = 32;
  localparam int MASK_W  = 8;
  localparam int EXP_W   = 31;
  localparam int PCNT_W  = 4;

  // Group (multicast) bit of a MAC address
  localparam int GROUP_BIT = 40;

  // Operation codes
  localparam logic [OP_W-1:0] OP_UNICAST   = 2'd0;
  localparam logic [OP_W-1:0] OP_BROADCAST = 2'd1;
  localparam logic [OP_W-1:0] OP_LOCAL     = 2'd2;

  // Configuration register map
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 31;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPIRY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PORTS  = 2'd2;

  // Configuration reset values
  localparam logic [EXP_W-1:0]  EXPIRY_RESET = 31'd300;
  localparam logic [PCNT_W-1:0] PORTS_RESET  = 4'd8;

  // Input transaction
  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [MAC_W-1:0]  src_mac;
    logic [MAC_W-1:0]  dst_mac;
    logic [PORT_W-1:0] in_port;
    logic [TIME_W-1:0] now_time;
  } in_item_t;

  // Result transaction
  typedef struct packed {
    logic [MASK_W-1:0] egress_mask;
    logic              lookup_hit;
    logic              aged_out;
    logic              learn_dropped;
  } out_item_t;

  // One MAC table entry as stored in memory
  typedef struct packed {
    logic              valid;
    logic [MAC_W-1:0]  mac;
    logic [PORT_W-1:0] port;
    logic [TIME_W-1:0] expiry;
  } entry_t;

  // Lookup outcome handed to the egress decision
  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [PORT_W-1:0] in_port;
    logic              found;
    logic [PORT_W-1:0] port;
    logic              aged;
    logic              dropped;
  } decide_t;

endpackage

// ===== hdl/mlbf_egress.sv =====
`timescale 1ns / 1ps
// Egress decision: turns a lookup outcome into the port mask and result flags.
// Depends on mlbf_pkg.
module mlbf_egress #(
  parameter int MAX_PORTS = mlbf_pkg::MAX_PORTS_DEF
) (
  input  mlbf_pkg::decide_t                dec,
  input  logic [mlbf_pkg::PCNT_W-1:0]      port_count,
  output mlbf_pkg::out_item_t              res
);

  logic [mlbf_pkg::MASK_W-1:0] all_mask;
  logic [mlbf_pkg::MASK_W-1:0] one_mask;
  logic [mlbf_pkg::MASK_W-1:0] flood_mask;
  logic                        port_ok;

  // Build the mask of attached ports
  always_comb begin
    for (int k = 0; k < mlbf_pkg::MASK_W; k++) begin
      all_mask[k] = (k < int'(port_count)) && (k < MAX_PORTS);
    end
  end

  assign port_ok = dec.found && (int'(dec.port) < int'(port_count)) &&
                   (int'(dec.port) < MAX_PORTS);
  assign one_mask   = mlbf_pkg::MASK_W'(1) << dec.port;
  assign flood_mask = all_mask & ~(mlbf_pkg::MASK_W'(1) << dec.in_port);

  // Pick single port or flood per operation
  always_comb begin
    res = '0;
    case (dec.operation)
      mlbf_pkg::OP_UNICAST, mlbf_pkg::OP_BROADCAST: begin
        if (port_ok && (dec.port != dec.in_port)) begin
          res.egress_mask = one_mask;
          res.lookup_hit  = 1'b1;
        end else begin
          res.egress_mask = flood_mask;
        end
        res.aged_out      = dec.aged;
        res.learn_dropped = dec.dropped;
      end
      mlbf_pkg::OP_LOCAL: begin
        if (port_ok) begin
          res.egress_mask = one_mask;
          res.lookup_hit  = 1'b1;
        end else begin
          res.egress_mask = all_mask;
        end
        res.aged_out = dec.aged;
      end
      default: res = '0;
    endcase
  end

endmodule

// ===== hdl/mac_learning_bridge_forward_unit.sv =====
`timescale 1ns / 1ps
// MAC learning bridge forwarding unit: MAC table memory, scan sequencer and result register.
// Depends on mlbf_pkg and mlbf_egress.
//
// Usage:
//   Input channel in_valid/in_stall/in_data carries one frame event. Result channel
//   out_valid/out_stall/out_data returns exactly one result per event. The
//   configuration channel cfg_valid/cfg_ready/cfg_index/cfg_data writes enable,
//   entry lifetime and port count; cfg_ready is always high.
//   The MAC table sits in one single-port-read, single-port-write memory with a
//   registered read. Each event that learns or looks up reads every entry once,
//   one per cycle, to find the source match, the first free or expired slot and
//   the destination match; then the LEARN state writes the learned entry and, on
//   an age-out, the AGE state clears it.
//   An event that neither learns nor looks up skips the scan and goes straight
//   to the LEARN and DONE states.
//   One event is in flight at a time; no new event is accepted until the last
//   has left DONE, and the table scan through the memory read port sets the rate.
//   After reset a clearing pass writes every entry invalid with in_stall high;
//   configuration writes are taken meanwhile.
//   A result waits in the output register while out_stall is high; the next event
//   may be accepted and scanned, and finishes once the register frees.
module mac_learning_bridge_forward_unit #(
  parameter int TABLE_ENTRIES = mlbf_pkg::TABLE_ENTRIES_DEF,
  parameter int MAX_PORTS     = mlbf_pkg::MAX_PORTS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  mlbf_pkg::in_item_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output mlbf_pkg::out_item_t                out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [mlbf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mlbf_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  // Sequencer states
  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_LEARN = 3'd3;
  localparam logic [2:0] ST_AGE   = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  function automatic logic is_live(input logic [mlbf_pkg::TIME_W-1:0] expiry,
                                   input logic [mlbf_pkg::TIME_W-1:0] now);
    logic [mlbf_pkg::TIME_W-1:0] d;
    d = expiry - now;
    return (d != '0) && !d[mlbf_pkg::TIME_W-1];
  endfunction

  // Configuration registers
  logic                          enable_r;
  logic [mlbf_pkg::EXP_W-1:0]    exp_ticks_r;
  logic [mlbf_pkg::PCNT_W-1:0]   port_count_r;

  // Sequencer and item registers
  logic [2:0]                    state_r, state_nxt;
  mlbf_pkg::in_item_t            item_r;
  logic                          do_learn_r, do_lookup_r;
  logic [IDX_W-1:0]              addr_r;
  logic                          issuing_r;
  logic                          rd_vld_r;
  logic [IDX_W-1:0]              rd_idx_r;

  // Scan results
  logic                          src_hit_r, free_hit_r, dst_hit_r, dst_live_r;
  logic [IDX_W-1:0]              src_idx_r, free_idx_r, dst_idx_r;
  logic [mlbf_pkg::PORT_W-1:0]   dst_port_r;

  // Lookup outcome
  logic                          found_r, aged_r, dropped_r;
  logic [mlbf_pkg::PORT_W-1:0]   port_r;
  logic [IDX_W-1:0]              age_idx_r;

  // Output register
  logic                          out_valid_r;
  mlbf_pkg::out_item_t           out_data_r;

  // Memory
  mlbf_pkg::entry_t              mem [TABLE_ENTRIES];
  mlbf_pkg::entry_t              rd_data_r;
  logic                          rd_en;
  logic                          wr_en;
  logic [IDX_W-1:0]              wr_addr;
  mlbf_pkg::entry_t              wr_data;

  // Learn-cycle decisions
  logic                          learn_ok;
  logic [IDX_W-1:0]              learn_idx;
  logic                          same_mac;
  logic                          found_nxt, aged_nxt;
  logic [mlbf_pkg::PORT_W-1:0]   port_nxt;
  logic [IDX_W-1:0]              age_idx_nxt;

  // Accept decode
  logic                          in_fire;
  logic                          is_fwd, learn_req, lookup_req;

  mlbf_pkg::decide_t             dec;
  mlbf_pkg::out_item_t           res;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign is_fwd     = (in_data.operation == mlbf_pkg::OP_UNICAST) ||
                      (in_data.operation == mlbf_pkg::OP_BROADCAST);
  assign learn_req  = enable_r && is_fwd;
  assign lookup_req = enable_r &&
                      ((in_data.operation == mlbf_pkg::OP_UNICAST) ||
                       ((in_data.operation == mlbf_pkg::OP_LOCAL) &&
                        !in_data.dst_mac[mlbf_pkg::GROUP_BIT]));

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r     <= 1'b1;
      exp_ticks_r  <= mlbf_pkg::EXPIRY_RESET;
      port_count_r <= mlbf_pkg::PORTS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mlbf_pkg::CFG_ENABLE: enable_r     <= cfg_data[0];
        mlbf_pkg::CFG_EXPIRY: exp_ticks_r  <= cfg_data[mlbf_pkg::EXP_W-1:0];
        mlbf_pkg::CFG_PORTS:  port_count_r <= cfg_data[mlbf_pkg::PCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Resolve learn slot and destination lookup after the scan
  always_comb begin
    learn_ok    = do_learn_r && (src_hit_r || free_hit_r);
    learn_idx   = src_hit_r ? src_idx_r : free_idx_r;
    same_mac    = (item_r.dst_mac == item_r.src_mac);
    found_nxt   = 1'b0;
    aged_nxt    = 1'b0;
    port_nxt    = dst_port_r;
    age_idx_nxt = dst_idx_r;
    if (do_lookup_r) begin
      if (do_learn_r && same_mac) begin
        // destination is the entry just learned
        if (learn_ok) begin
          port_nxt    = item_r.in_port;
          age_idx_nxt = learn_idx;
          if (exp_ticks_r != '0) begin
            found_nxt = 1'b1;
          end else begin
            aged_nxt = 1'b1;
          end
        end
      end else if (dst_hit_r) begin
        // a new source that reuses the destination's expired slot hides it
        if (!(learn_ok && !src_hit_r && (free_idx_r == dst_idx_r))) begin
          if (dst_live_r) begin
            found_nxt = 1'b1;
          end else begin
            aged_nxt = 1'b1;
          end
        end
      end
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (addr_r == LAST_IDX) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_fire) state_nxt = (learn_req || lookup_req) ? ST_SCAN : ST_LEARN;
      end
      ST_SCAN:  if (!issuing_r && rd_vld_r) state_nxt = ST_LEARN;
      ST_LEARN: state_nxt = aged_nxt ? ST_AGE : ST_DONE;
      ST_AGE:   state_nxt = ST_DONE;
      ST_DONE:  if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Memory port control
  assign rd_en = (state_r == ST_SCAN) && issuing_r;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = addr_r;
    wr_data = '0;
    case (state_r)
      ST_CLEAR: wr_en = 1'b1;
      ST_LEARN: begin
        wr_en          = learn_ok;
        wr_addr        = learn_idx;
        wr_data.valid  = 1'b1;
        wr_data.mac    = item_r.src_mac;
        wr_data.port   = item_r.in_port;
        wr_data.expiry = item_r.now_time + {1'b0, exp_ticks_r};
      end
      ST_AGE: begin
        wr_en   = 1'b1;
        wr_addr = age_idx_r;
      end
      default: wr_en = 1'b0;
    endcase
  end

  // MAC table memory with registered read
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= mem[addr_r];
  end

  // Sequencer, scan bookkeeping and item capture
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      addr_r    <= '0;
      issuing_r <= 1'b0;
      rd_vld_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= rd_en;
      case (state_r)
        ST_CLEAR: addr_r <= addr_r + IDX_W'(1);
        ST_IDLE: begin
          addr_r    <= '0;
          issuing_r <= in_fire && (learn_req || lookup_req);
        end
        ST_SCAN: begin
          if (issuing_r) begin
            addr_r <= addr_r + IDX_W'(1);
            if (addr_r == LAST_IDX) issuing_r <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Capture item and evaluate each entry read back
  always_ff @(posedge clk) begin
    rd_idx_r <= addr_r;
    if (in_fire) begin
      item_r      <= in_data;
      do_learn_r  <= learn_req;
      do_lookup_r <= lookup_req;
      src_hit_r   <= 1'b0;
      free_hit_r  <= 1'b0;
      dst_hit_r   <= 1'b0;
    end else if (rd_vld_r) begin
      if (rd_data_r.valid && (rd_data_r.mac == item_r.src_mac) && !src_hit_r) begin
        src_hit_r <= 1'b1;
        src_idx_r <= rd_idx_r;
      end
      if ((!rd_data_r.valid || !is_live(rd_data_r.expiry, item_r.now_time)) &&
          !free_hit_r) begin
        free_hit_r <= 1'b1;
        free_idx_r <= rd_idx_r;
      end
      if (rd_data_r.valid && (rd_data_r.mac == item_r.dst_mac) && !dst_hit_r) begin
        dst_hit_r  <= 1'b1;
        dst_idx_r  <= rd_idx_r;
        dst_port_r <= rd_data_r.port;
        dst_live_r <= is_live(rd_data_r.expiry, item_r.now_time);
      end
    end
  end

  // Hold the lookup outcome for the result
  always_ff @(posedge clk) begin
    if (state_r == ST_LEARN) begin
      found_r   <= found_nxt;
      aged_r    <= aged_nxt;
      port_r    <= port_nxt;
      age_idx_r <= age_idx_nxt;
      dropped_r <= do_learn_r && !learn_ok;
    end
  end

  assign dec.operation = item_r.operation;
  assign dec.in_port   = item_r.in_port;
  assign dec.found     = found_r;
  assign dec.port      = port_r;
  assign dec.aged      = aged_r;
  assign dec.dropped   = dropped_r;

  mlbf_egress #(
    .MAX_PORTS (MAX_PORTS)
  ) u_egress (
    .dec        (dec),
    .port_count (port_count_r),
    .res        (res)
  );

  // Output register: load in DONE, drop when the transaction completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == ST_DONE) && (!out_valid_r || !out_stall)) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_DONE) && (!out_valid_r || !out_stall)) out_data_r <= res;
  end

endmodule

// ===== hdl/mlbf_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the MAC learning bridge forwarding unit, bound to the top level.
// Depends on mlbf_pkg.
module mlbf_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input mlbf_pkg::out_item_t out_data
);

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // One event at a time: the input stalls right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while an event is in flight");

  // A hit names exactly one port
  a_hit_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.lookup_hit) |-> $onehot(out_data.egress_mask))
    else $error("lookup_hit with a mask that is not one-hot");

  // An aged-out entry never selects a port
  a_aged_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.aged_out && out_data.lookup_hit))
    else $error("aged_out and lookup_hit both set");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

endmodule

bind mac_learning_bridge_forward_unit mlbf_checker u_mlbf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
